### src/tmi_pkg.sv
// Shared types and constants for the tape machine interpreter core.
// No dependencies; imported by every module of the block.
`default_nettype none
package tmi_pkg;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_STEP  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FIN  = 2'd1;
  localparam logic [1:0] ST_HALT = 2'd2;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_RIGHT = 3'd1;
  localparam logic [2:0] ERR_LEFT  = 3'd2;
  localparam logic [2:0] ERR_OPEN  = 3'd3;
  localparam logic [2:0] ERR_CLOSE = 3'd4;

  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_IN    = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  localparam logic REG_CELL_MODE = 1'b0;
  localparam logic REG_MEM_SIZE  = 1'b1;

  typedef struct packed {
    logic latch;
    logic load;
    logic clr;
    logic fetch;
    logic exec;
    logic sf_adv;
    logic sf_chk;
    logic sb_adv;
    logic sb_chk;
    logic resp;
  } tmi_cmd_t;

  typedef struct packed {
    logic is_load;
    logic is_clear;
    logic is_step;
    logic halted;
    logic at_end;
    logic need_fwd;
    logic need_bwd;
    logic sf_stop;
    logic sf_match;
    logic sb_stop;
    logic sb_match;
    logic clr_last;
    logic out_free;
  } tmi_sts_t;

endpackage
`default_nettype wire

### src/tmi_ctrl.sv
// Sequencer for the tape machine interpreter core.
// Depends on tmi_pkg; drives commands into tmi_dp and reads its status.
`default_nettype none
module tmi_ctrl import tmi_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire tmi_sts_t sts,
  output tmi_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_FETCH = 4'd3;
  localparam logic [3:0] S_EXEC  = 4'd4;
  localparam logic [3:0] S_SFA   = 4'd5;
  localparam logic [3:0] S_SFC   = 4'd6;
  localparam logic [3:0] S_SBA   = 4'd7;
  localparam logic [3:0] S_SBC   = 4'd8;
  localparam logic [3:0] S_RESP  = 4'd9;

  logic [3:0] state, state_next;
  logic       clr_resp, clr_resp_next;

  always_comb begin
    state_next    = state;
    clr_resp_next = clr_resp;
    cmd           = '0;
    in_stall      = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (sts.is_load) begin
            state_next = S_LOAD;
          end else if (sts.is_clear) begin
            state_next    = S_CLR;
            clr_resp_next = 1'b1;
          end else if (sts.is_step) begin
            state_next = S_FETCH;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_RESP;
      end
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next    = clr_resp ? S_RESP : S_IDLE;
          clr_resp_next = 1'b0;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = (sts.halted || sts.at_end) ? S_RESP : S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.need_fwd) begin
          state_next = S_SFA;
        end else if (sts.need_bwd) begin
          state_next = S_SBA;
        end else begin
          state_next = S_RESP;
        end
      end
      S_SFA: begin
        cmd.sf_adv = 1'b1;
        state_next = sts.sf_stop ? S_RESP : S_SFC;
      end
      S_SFC: begin
        cmd.sf_chk = 1'b1;
        state_next = sts.sf_match ? S_RESP : S_SFA;
      end
      S_SBA: begin
        cmd.sb_adv = 1'b1;
        state_next = sts.sb_stop ? S_RESP : S_SBC;
      end
      S_SBC: begin
        cmd.sb_chk = 1'b1;
        state_next = sts.sb_match ? S_RESP : S_SBA;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.resp   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_resp <= 1'b0;
    end else begin
      state    <= state_next;
      clr_resp <= clr_resp_next;
    end
  end

endmodule
`default_nettype wire

### src/tmi_dp.sv
// Datapath of the tape machine interpreter core: program and tape memories,
// machine registers, config registers and the result word register. Uses tmi_pkg.
`default_nettype none
module tmi_dp import tmi_pkg::*; #(
  parameter int PROG_DEPTH    = 4096,
  parameter int MEM_DEPTH     = 4096,
  parameter int CELL_MAX_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tmi_cmd_t           cmd,
  output tmi_sts_t                sts,
  input  wire logic [1:0]         func,
  input  wire logic [7:0]         prog_byte,
  input  wire logic               prog_first,
  input  wire logic signed [31:0] input_value,
  input  wire logic               input_eof,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output logic [1:0]              status,
  output logic [2:0]              error_code,
  output logic                    out_valid,
  output logic signed [31:0]      out_value,
  output logic [12:0]             program_counter,
  output logic [11:0]             tape_position,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata
);

  localparam int PL_W  = $clog2(PROG_DEPTH + 1);
  localparam int PA_W  = $clog2(PROG_DEPTH);
  localparam int MA_W  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int SZ_W  = ($clog2(MEM_DEPTH + 1) > 13) ? $clog2(MEM_DEPTH + 1) : 13;
  localparam int CW    = CELL_MAX_BITS;

  logic [7:0]      prog_mem [PROG_DEPTH];
  logic [CW-1:0]   data_mem [MEM_DEPTH];
  logic [7:0]      prog_rd;
  logic [CW-1:0]   data_rd;

  logic [1:0]      cell_mode;
  logic [SZ_W-1:0] mem_size;
  logic [PL_W-1:0] len, pc, p, depth;
  logic [MA_W-1:0] dp, clr_idx;
  logic [PA_W-1:0] lc;
  logic            lcv, halted;
  logic [2:0]      last_err;

  logic [1:0]      l_func;
  logic [7:0]      l_byte;
  logic            l_first, l_eof;
  logic [31:0]     l_ival;
  logic [1:0]      r_status;
  logic [2:0]      r_err;
  logic            r_ov;
  logic [31:0]     r_oval;

  logic [5:0]      cbits;
  logic [31:0]     cell_val;
  logic [SZ_W-1:0] eff;
  logic            right_fault;
  logic [PL_W-1:0] wr_idx;
  logic            wr_ok;
  logic [PA_W-1:0] prog_raddr;
  logic            dwe;
  logic [MA_W-1:0] dwaddr;
  logic [CW-1:0]   dwdata;
  logic            cfg_wr;

  function automatic logic [31:0] norm(input logic [31:0] v, input logic [5:0] b);
    logic [31:0] r;
    logic [4:0]  sb;
    sb = 5'(b - 6'd1);
    for (int i = 0; i < 32; i++) begin
      r[i] = (i < 32'(b)) ? v[i] : v[sb];
    end
    return r;
  endfunction

  always_comb begin
    cbits = (cell_mode == 2'd0) ? 6'd8 : (cell_mode == 2'd1) ? 6'd16 : 6'd32;
    if (32'(cbits) > CW) cbits = 6'(CW);
    cell_val = norm(32'(data_rd), cbits);
    if (mem_size == '0) begin
      eff = SZ_W'(1);
    end else if (mem_size > SZ_W'(MEM_DEPTH)) begin
      eff = SZ_W'(MEM_DEPTH);
    end else begin
      eff = mem_size;
    end
    right_fault = (SZ_W'(dp) + SZ_W'(1)) >= eff;
    wr_idx = l_first ? '0 : len;
    wr_ok  = wr_idx < PL_W'(PROG_DEPTH);
    if (cmd.sf_adv) begin
      prog_raddr = PA_W'(p + PL_W'(1));
    end else if (cmd.sb_adv) begin
      prog_raddr = PA_W'(p - PL_W'(1));
    end else begin
      prog_raddr = PA_W'(pc);
    end
    dwe    = 1'b0;
    dwaddr = dp;
    dwdata = '0;
    if (cmd.clr) begin
      dwe    = 1'b1;
      dwaddr = clr_idx;
    end else if (cmd.exec) begin
      case (prog_rd)
        CH_INC: begin
          dwe    = 1'b1;
          dwdata = CW'(norm(cell_val + 32'd1, cbits));
        end
        CH_DEC: begin
          dwe    = 1'b1;
          dwdata = CW'(norm(cell_val - 32'd1, cbits));
        end
        CH_IN: begin
          dwe    = !l_eof;
          dwdata = CW'(norm(l_ival, cbits));
        end
        default: dwe = 1'b0;
      endcase
    end
    cfg_wr = psel && penable && pwrite;
  end

  always_comb begin
    sts.is_load  = (func == FUNC_LOAD);
    sts.is_clear = (func == FUNC_CLEAR);
    sts.is_step  = (func == FUNC_STEP);
    sts.halted   = halted;
    sts.at_end   = pc >= len;
    sts.need_fwd = (prog_rd == CH_OPEN) && (cell_val == '0);
    sts.need_bwd = (prog_rd == CH_CLOSE) && (cell_val != '0) && !lcv;
    sts.sf_stop  = (p + PL_W'(1)) >= len;
    sts.sf_match = (prog_rd == CH_CLOSE) && (depth == '0);
    sts.sb_stop  = (p == '0);
    sts.sb_match = (prog_rd == CH_OPEN) && (depth == '0);
    sts.clr_last = (clr_idx == MA_W'(MEM_DEPTH - 1));
    sts.out_free = !res_valid || !res_stall;
  end

  always_comb begin
    unique case (paddr[2])
      REG_CELL_MODE: prdata = 32'(cell_mode);
      REG_MEM_SIZE:  prdata = 32'(mem_size);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prog_rd <= prog_mem[prog_raddr];
    if (cmd.load && wr_ok) prog_mem[PA_W'(wr_idx)] <= l_byte;
  end

  always_ff @(posedge clk) begin
    data_rd <= data_mem[dp];
    if (dwe) data_mem[dwaddr] <= dwdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_mode <= 2'd0;
      mem_size  <= SZ_W'(MEM_DEPTH);
      len       <= '0;
      pc        <= '0;
      dp        <= '0;
      lc        <= '0;
      lcv       <= 1'b0;
      halted    <= 1'b0;
      last_err  <= ERR_NONE;
      clr_idx   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_CELL_MODE: cell_mode <= pwdata[1:0];
          REG_MEM_SIZE:  mem_size  <= SZ_W'(pwdata[12:0]);
          default:       cell_mode <= cell_mode;
        endcase
      end
      if (cmd.load) begin
        if (l_first) begin
          pc       <= '0;
          lc       <= '0;
          lcv      <= 1'b0;
          halted   <= 1'b0;
          last_err <= ERR_NONE;
        end
        len <= wr_ok ? wr_idx + PL_W'(1) : wr_idx;
      end
      if (cmd.clr) begin
        clr_idx <= sts.clr_last ? '0 : clr_idx + MA_W'(1);
        dp      <= '0;
      end
      if (cmd.exec) begin
        case (prog_rd)
          CH_RIGHT: begin
            if (right_fault) begin
              halted   <= 1'b1;
              last_err <= ERR_RIGHT;
            end else begin
              dp <= dp + MA_W'(1);
              pc <= pc + PL_W'(1);
            end
          end
          CH_LEFT: begin
            if (dp == '0) begin
              halted   <= 1'b1;
              last_err <= ERR_LEFT;
            end else begin
              dp <= dp - MA_W'(1);
              pc <= pc + PL_W'(1);
            end
          end
          CH_OPEN: begin
            if (cell_val != '0) begin
              lc  <= PA_W'(pc);
              lcv <= 1'b1;
              pc  <= pc + PL_W'(1);
            end
          end
          CH_CLOSE: begin
            if (cell_val == '0) begin
              lcv <= 1'b0;
              pc  <= pc + PL_W'(1);
            end else if (lcv) begin
              pc <= PL_W'(lc) + PL_W'(1);
            end
          end
          default: pc <= pc + PL_W'(1);
        endcase
      end
      if (cmd.sf_adv && sts.sf_stop) begin
        halted   <= 1'b1;
        last_err <= ERR_OPEN;
      end
      if (cmd.sf_chk && sts.sf_match) pc <= p + PL_W'(1);
      if (cmd.sb_adv && sts.sb_stop) begin
        halted   <= 1'b1;
        last_err <= ERR_CLOSE;
      end
      if (cmd.sb_chk && sts.sb_match) begin
        pc  <= p + PL_W'(1);
        lc  <= PA_W'(p);
        lcv <= 1'b1;
      end
      if (cmd.resp) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      l_func   <= func;
      l_byte   <= prog_byte;
      l_first  <= prog_first;
      l_ival   <= input_value;
      l_eof    <= input_eof;
      r_status <= ST_OK;
      r_err    <= ERR_NONE;
      r_ov     <= 1'b0;
      r_oval   <= '0;
    end
    if (cmd.fetch && l_func == FUNC_STEP) begin
      if (halted) begin
        r_status <= ST_HALT;
        r_err    <= last_err;
      end else if (sts.at_end) begin
        r_status <= ST_FIN;
      end
    end
    if (cmd.exec) begin
      p     <= pc;
      depth <= '0;
      case (prog_rd)
        CH_RIGHT: begin
          if (right_fault) begin
            r_status <= ST_HALT;
            r_err    <= ERR_RIGHT;
          end
        end
        CH_LEFT: begin
          if (dp == '0) begin
            r_status <= ST_HALT;
            r_err    <= ERR_LEFT;
          end
        end
        CH_OUT: begin
          r_ov   <= 1'b1;
          r_oval <= cell_val;
        end
        default: r_ov <= r_ov;
      endcase
    end
    if (cmd.sf_adv) begin
      p <= p + PL_W'(1);
      if (sts.sf_stop) begin
        r_status <= ST_HALT;
        r_err    <= ERR_OPEN;
      end
    end
    if (cmd.sf_chk) begin
      if (prog_rd == CH_CLOSE && depth != '0) depth <= depth - PL_W'(1);
      if (prog_rd == CH_OPEN) depth <= depth + PL_W'(1);
    end
    if (cmd.sb_adv) begin
      if (sts.sb_stop) begin
        r_status <= ST_HALT;
        r_err    <= ERR_CLOSE;
      end else begin
        p <= p - PL_W'(1);
      end
    end
    if (cmd.sb_chk) begin
      if (prog_rd == CH_OPEN && depth != '0) depth <= depth - PL_W'(1);
      if (prog_rd == CH_CLOSE) depth <= depth + PL_W'(1);
    end
    if (cmd.resp) begin
      status          <= r_status;
      error_code      <= r_err;
      out_valid       <= r_ov;
      out_value       <= r_oval;
      program_counter <= 13'(pc);
      tape_position   <= 12'(dp);
    end
  end

endmodule
`default_nettype wire

### src/tape_machine_interpreter_core_top.sv
// Sequence: a step skips execution when halted or past the end, and a bracket skip
// scans the program byte by byte; a clear writes every tape cell.
// Throughput: one item at a time; next word accepted the cycle after the result is registered.
// Ordinary commands: fetch, cell read-modify-write, result register.
// Reset: tape clearing pass over every cell, no words accepted meanwhile.
// Top level; instantiates tmi_ctrl and tmi_dp, uses tmi_pkg.
`default_nettype none
module tape_machine_interpreter_core_top import tmi_pkg::*; #(
  parameter int PROG_DEPTH    = 4096,
  parameter int MEM_DEPTH     = 4096,
  parameter int CELL_MAX_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         func,
  input  wire logic [7:0]         prog_byte,
  input  wire logic               prog_first,
  input  wire logic signed [31:0] input_value,
  input  wire logic               input_eof,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output logic [1:0]              status,
  output logic [2:0]              error_code,
  output logic                    out_valid,
  output logic signed [31:0]      out_value,
  output logic [12:0]             program_counter,
  output logic [11:0]             tape_position,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  tmi_cmd_t cmd;
  tmi_sts_t sts;

  assign pready = 1'b1;

  tmi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tmi_dp #(
    .PROG_DEPTH    (PROG_DEPTH),
    .MEM_DEPTH     (MEM_DEPTH),
    .CELL_MAX_BITS (CELL_MAX_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .func            (func),
    .prog_byte       (prog_byte),
    .prog_first      (prog_first),
    .input_value     (input_value),
    .input_eof       (input_eof),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .status          (status),
    .error_code      (error_code),
    .out_valid       (out_valid),
    .out_value       (out_value),
    .program_counter (program_counter),
    .tape_position   (tape_position),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata)
  );

endmodule
`default_nettype wire

### src/tmi_chk.sv
// Port-level checker for the tape machine interpreter core, bound to the top.
// Uses tmi_pkg for status and error codes.
`default_nettype none
module tmi_chk import tmi_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_stall,
  input wire logic [1:0] status,
  input wire logic [2:0] error_code,
  input wire logic       out_valid
);

  a_rst_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(status) && $stable(error_code))
    else $error("stalled result word changed");

  a_err_none: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != ST_HALT |-> error_code == ERR_NONE)
    else $error("error code without halt");

  a_err_set: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_HALT |-> error_code != ERR_NONE && error_code <= ERR_CLOSE)
    else $error("halt without valid error code");

  a_out_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_valid |-> status == ST_OK)
    else $error("output command with non-ok status");

endmodule

bind tape_machine_interpreter_core_top tmi_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .status     (status),
  .error_code (error_code),
  .out_valid  (out_valid)
);
`default_nettype wire
